[hw/rtl/mfr_pkg.sv]
// Shared types and constants for the multidrop frame receiver.
// Depends on nothing; every other RTL file imports this package.
`default_nettype none

package mfr_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_NODE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_FRAME_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_ASK_CODE     = 2'd2;

    // Configuration reset values.
    localparam logic [4:0] RST_NODE_ADDRESS = 5'd2;
    localparam logic [4:0] RST_FRAME_LIMIT  = 5'd30;
    localparam logic [7:0] RST_ASK_CODE     = 8'd29;

    // Depth of the two small queues.
    localparam logic [1:0] QUEUE_DEPTH = 2'd2;

    // Word class decided by the front end.
    typedef enum logic [1:0] {
        K_IGNORE = 2'd0,
        K_START  = 2'd1,
        K_DATA   = 2'd2
    } t_kind;

    // Status code reported with each result.
    typedef enum logic [2:0] {
        ST_IGNORED = 3'd0,
        ST_START   = 3'd1,
        ST_STORED  = 3'd2,
        ST_GOOD    = 3'd3,
        ST_XOR_ERR = 3'd4,
        ST_ABORT   = 3'd5
    } t_status;

    // Classified word passed from front to back.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] byte_val;
    } t_cmd;

    // One result item.
    typedef struct packed {
        t_status     status;
        logic [7:0]  data_byte;
        logic [4:0]  byte_index;
        logic [7:0]  command_byte;
        logic [15:0] ask_total;
        logic        receiving;
    } t_result;

endpackage

`default_nettype wire

[hw/rtl/multidrop_frame_receiver.sv]
// Multidrop frame receiver top level: configuration registers, front and back end.
// Depends on mfr_pkg, mfr_front and mfr_back.
//
// Takes one 9-bit received word per transfer and returns exactly one result per
// word, in order. Words enter through a two-entry queue after classification and
// leave through a two-entry result queue, so a word can be taken in every clock
// cycle as long as results are popped and the queues do not fill up; a word waits
// in the front queue and its result in the result queue before it can be popped.
// Rate is set by the frame state update in the back end (XOR, length and limit
// compares). Configuration writes take effect on the next cycle and should be
// made only while no word is in flight.
`default_nettype none

module multidrop_frame_receiver
    import mfr_pkg::*;
#(
    parameter int MAX_BYTES = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [8:0]  i_rx_word,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [2:0]       o_status,
    output logic [7:0]       o_data_byte,
    output logic [4:0]       o_byte_index,
    output logic [7:0]       o_command_byte,
    output logic [15:0]      o_ask_total,
    output logic             o_receiving,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    logic [4:0] r_node_address;
    logic [4:0] r_frame_limit;
    logic [7:0] r_ask_code;
    logic [4:0] w_limit;
    logic       w_cmd_valid;
    logic       w_cmd_ready;
    t_cmd       w_cmd;
    t_result    w_result;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_address <= RST_NODE_ADDRESS;
            r_frame_limit  <= RST_FRAME_LIMIT;
            r_ask_code     <= RST_ASK_CODE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NODE_ADDRESS: r_node_address <= i_cfg_data[4:0];
                CFG_FRAME_LIMIT:  r_frame_limit  <= i_cfg_data[4:0];
                CFG_ASK_CODE:     r_ask_code     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Effective limit: the frame limit capped at the buffer size.
    always_comb begin
        if ({4'b0000, r_frame_limit} > 9'(MAX_BYTES)) begin
            w_limit = 5'(MAX_BYTES);
        end else begin
            w_limit = r_frame_limit;
        end
    end

    mfr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_rx_word      (i_rx_word),
        .i_node_address (r_node_address),
        .o_cmd_valid    (w_cmd_valid),
        .o_cmd          (w_cmd),
        .i_cmd_ready    (w_cmd_ready)
    );

    mfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .i_limit     (w_limit),
        .i_ask_code  (r_ask_code),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_result    (w_result)
    );

    // Result fields.
    assign o_status       = w_result.status;
    assign o_data_byte    = w_result.data_byte;
    assign o_byte_index   = w_result.byte_index;
    assign o_command_byte = w_result.command_byte;
    assign o_ask_total    = w_result.ask_total;
    assign o_receiving    = w_result.receiving;

endmodule

`default_nettype wire

[hw/rtl/mfr_front.sv]
// Front end of the frame receiver: classifies received words and queues them.
// Depends on mfr_pkg for the classified word type and queue depth.
`default_nettype none

module mfr_front
    import mfr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    output logic            o_full,
    input  wire logic [8:0] i_rx_word,
    input  wire logic [4:0] i_node_address,
    output logic            o_cmd_valid,
    output t_cmd            o_cmd,
    input  wire logic       i_cmd_ready
);

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    t_cmd       w_class;
    logic       w_push;
    logic       w_pop;

    // Address words either start a frame for this node or are ignored.
    always_comb begin
        w_class.byte_val = i_rx_word[7:0];
        if (i_rx_word[8]) begin
            w_class.kind = (i_rx_word[4:0] == i_node_address) ? K_START : K_IGNORE;
        end else begin
            w_class.kind = K_DATA;
        end
    end

    // Queue handshakes.
    assign o_full      = (r_count == QUEUE_DEPTH);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_slot[r_rd_ptr];
    assign w_push      = i_push && !o_full;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_class;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_DEPTH)
        else $error("front queue overfilled");

    // A transfer in without one out grows the queue by one.
    a_count_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + 2'd1))
        else $error("front queue count did not follow a transfer");

endmodule

`default_nettype wire

[hw/rtl/mfr_back.sv]
// Back end of the frame receiver: frame state, XOR check and the result queue.
// Depends on mfr_pkg for the command and result types.
`default_nettype none

module mfr_back
    import mfr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cmd_valid,
    input  wire t_cmd       i_cmd,
    output logic            o_cmd_ready,
    input  wire logic [4:0] i_limit,
    input  wire logic [7:0] i_ask_code,
    output logic            o_empty,
    input  wire logic       i_pop,
    output t_result         o_result
);

    logic        r_busy;
    logic [4:0]  r_bcount;
    logic [7:0]  r_flen;
    logic [7:0]  r_xor;
    logic [7:0]  r_cmd;
    logic [15:0] r_ask;
    logic        n_busy;
    logic [4:0]  n_bcount;
    logic [7:0]  n_flen;
    logic [7:0]  n_xor;
    logic [7:0]  n_cmd;
    logic [15:0] n_ask;
    t_result     w_res;
    logic        w_take;
    logic        w_out_pop;

    t_result     r_slot [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_rcount;

    assign o_cmd_ready = (r_rcount != QUEUE_DEPTH);
    assign w_take      = i_cmd_valid && o_cmd_ready;
    assign o_empty     = (r_rcount == 2'd0);
    assign w_out_pop   = i_pop && !o_empty;
    assign o_result    = r_slot[r_rd_ptr];

    // Frame state update for one classified word.
    always_comb begin
        n_busy           = r_busy;
        n_bcount         = r_bcount;
        n_flen           = r_flen;
        n_xor            = r_xor;
        n_cmd            = r_cmd;
        n_ask            = r_ask;
        w_res.status     = ST_IGNORED;
        w_res.data_byte  = 8'd0;
        w_res.byte_index = 5'd0;
        case (i_cmd.kind)
            K_START: begin
                n_bcount     = 5'd0;
                n_busy       = 1'b1;
                n_xor        = 8'd0;
                w_res.status = ST_START;
            end
            K_DATA: begin
                if (r_busy) begin
                    if (r_bcount >= i_limit) begin
                        // Counter at the limit: abort without storing.
                        n_busy       = 1'b0;
                        w_res.status = ST_ABORT;
                    end else begin
                        w_res.byte_index = r_bcount;
                        w_res.data_byte  = i_cmd.byte_val;
                        if (r_bcount == 5'd0) begin
                            n_flen = i_cmd.byte_val;
                        end
                        if (r_bcount == 5'd1) begin
                            n_cmd = i_cmd.byte_val;
                        end
                        n_xor        = r_xor ^ i_cmd.byte_val;
                        n_bcount     = r_bcount + 5'd1;
                        w_res.status = ST_STORED;
                        if (n_flen > {3'b000, i_limit}) begin
                            // Declared length too large.
                            n_busy       = 1'b0;
                            w_res.status = ST_ABORT;
                        end else if ({3'b000, n_bcount} > n_flen) begin
                            // Last byte holds the check value.
                            n_busy = 1'b0;
                            if (r_xor == i_cmd.byte_val) begin
                                w_res.status = ST_GOOD;
                                if (n_cmd == i_ask_code) begin
                                    n_ask = r_ask + 16'd1;
                                end
                            end else begin
                                w_res.status = ST_XOR_ERR;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        w_res.command_byte = n_cmd;
        w_res.ask_total    = n_ask;
        w_res.receiving    = n_busy;
    end

    // Frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_bcount <= 5'd0;
            r_flen   <= 8'd0;
            r_xor    <= 8'd0;
            r_cmd    <= 8'd0;
            r_ask    <= 16'd0;
        end else if (w_take) begin
            r_busy   <= n_busy;
            r_bcount <= n_bcount;
            r_flen   <= n_flen;
            r_xor    <= n_xor;
            r_cmd    <= n_cmd;
            r_ask    <= n_ask;
        end
    end

    // Result queue storage.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_slot[r_wr_ptr] <= w_res;
        end
    end

    // Result queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_rcount <= 2'd0;
        end else begin
            if (w_take) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_out_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_take && !w_out_pop) begin
                r_rcount <= r_rcount + 2'd1;
            end else if (w_out_pop && !w_take) begin
                r_rcount <= r_rcount - 2'd1;
            end
        end
    end

    // The result queue never overfills.
    a_rcount_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcount <= QUEUE_DEPTH)
        else $error("result queue overfilled");

    // The ask counter moves only when a word is processed.
    a_ask_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_take |=> $stable(r_ask))
        else $error("ask counter changed without a word");

    // An abort always ends reception.
    a_abort_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_res.status == ST_ABORT) |=> !r_busy)
        else $error("reception continued after an abort");

endmodule

`default_nettype wire

[test/multidrop_frame_receiver_test.sv]
// Self-checking testbench for the multidrop frame receiver.
// It drives received words and register writes and checks every result against its own frame model.
// Depends on mfr_pkg and multidrop_frame_receiver.
module multidrop_frame_receiver_test;
    import mfr_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int MAX_BYTES    = 32;
    localparam int RANDOM_WORDS = 1150;
    localparam int PHASES       = 8;
    localparam int CFG_SETTLE   = 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 500000;

    typedef enum logic {
        OP_WORD,
        OP_CFG
    } op_kind_t;

    // One entry of the stimulus queue: a received word or a register write.
    typedef struct {
        op_kind_t   kind;
        logic [8:0] word;
        logic [1:0] cfg_index;
        logic [7:0] cfg_data;
    } bus_op_t;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_push      = 1'b0;
    logic [8:0]  i_rx_word   = '0;
    logic        i_pop       = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_index = CFG_NODE_ADDRESS;
    logic [7:0]  i_cfg_data  = '0;
    logic        o_full;
    logic        o_empty;
    logic [2:0]  o_status;
    logic [7:0]  o_data_byte;
    logic [4:0]  o_byte_index;
    logic [7:0]  o_command_byte;
    logic [15:0] o_ask_total;
    logic        o_receiving;

    // Frame model state and its copy of the registers.
    logic [4:0]  node_addr = RST_NODE_ADDRESS;
    logic [4:0]  frame_lim = RST_FRAME_LIMIT;
    logic [7:0]  ask_code  = RST_ASK_CODE;
    logic        rx_busy   = 1'b0;
    logic [4:0]  rx_count  = '0;
    logic [7:0]  rx_length = '0;
    logic [7:0]  rx_xor    = '0;
    logic [7:0]  cmd_hold  = '0;
    logic [15:0] ask_cnt   = '0;

    bus_op_t pending_ops[$];
    t_result expected_results[$];

    int failures    = 0;
    int words_sent  = 0;
    int cfg_writes  = 0;
    int frame_words = 0;
    int cycles      = 0;
    int status_seen[8];

    int push_gap   = 0;
    int pop_gap    = 0;
    int cfg_settle = CFG_SETTLE;
    bit push_quiet = 1'b0;
    bit pop_quiet  = 1'b0;

    multidrop_frame_receiver #(
        .MAX_BYTES(MAX_BYTES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_rx_word     (i_rx_word),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_status      (o_status),
        .o_data_byte   (o_data_byte),
        .o_byte_index  (o_byte_index),
        .o_command_byte(o_command_byte),
        .o_ask_total   (o_ask_total),
        .o_receiving   (o_receiving),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Advance the frame model by one received word and return the result it predicts.
    function automatic t_result receive_word(input logic [8:0] word);
        t_result    res;
        logic [7:0] data;
        logic [7:0] prev_xor;
        int         limit;
        data  = word[7:0];
        limit = (int'(frame_lim) > MAX_BYTES) ? MAX_BYTES : int'(frame_lim);
        res   = '0;
        res.status = ST_IGNORED;
        if (word[8]) begin
            // A foreign address leaves a frame in progress untouched.
            if (word[4:0] == node_addr) begin
                rx_count   = '0;
                rx_busy    = 1'b1;
                rx_xor     = '0;
                res.status = ST_START;
            end
        end else if (rx_busy) begin
            if (int'(rx_count) >= limit) begin
                rx_busy    = 1'b0;
                res.status = ST_ABORT;
            end else begin
                prev_xor       = rx_xor;
                res.byte_index = rx_count;
                res.data_byte  = data;
                if (rx_count == 5'd0) rx_length = data;
                if (rx_count == 5'd1) cmd_hold = data;
                rx_xor     = prev_xor ^ data;
                rx_count   = rx_count + 5'd1;
                res.status = ST_STORED;
                if (int'(rx_length) > limit) begin
                    rx_busy    = 1'b0;
                    res.status = ST_ABORT;
                end else if (8'(rx_count) > rx_length) begin
                    // The last byte carries the XOR of all bytes before it.
                    rx_busy = 1'b0;
                    if (prev_xor == data) begin
                        res.status = ST_GOOD;
                        if (cmd_hold == ask_code) ask_cnt = ask_cnt + 16'd1;
                    end else begin
                        res.status = ST_XOR_ERR;
                    end
                end
            end
        end
        res.command_byte = cmd_hold;
        res.ask_total    = ask_cnt;
        res.receiving    = rx_busy;
        return res;
    endfunction

    // Idle length between transfers: mostly none or short, now and then long.
    function automatic int pick_gap(input bit quiet);
        int roll;
        if (quiet) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endfunction

    task automatic queue_word(input logic [8:0] word);
        pending_ops.push_back('{OP_WORD, word, CFG_NODE_ADDRESS, 8'h00});
    endtask

    task automatic queue_cfg(input logic [1:0] index, input logic [7:0] data);
        pending_ops.push_back('{OP_CFG, 9'h000, index, data});
    endtask

    // Queue an address word and up to stop_at bytes of a frame of the given length.
    task automatic queue_frame(input logic [4:0] node, input logic [7:0] len,
                               input logic [7:0] cmd, input bit bad_sum, input int stop_at);
        logic [7:0] body;
        logic [7:0] sum;
        sum = '0;
        queue_word({1'b1, 3'($urandom_range(0, 7)), node});
        frame_words++;
        for (int k = 0; k <= int'(len) && k < stop_at; k++) begin
            if (k == int'(len))
                body = bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum;
            else if (k == 0)
                body = len;
            else if (k == 1)
                body = cmd;
            else
                body = 8'($urandom);
            sum = sum ^ body;
            queue_word({1'b0, body});
            frame_words++;
        end
    endtask

    // Driver: takes words and register writes from the pending queue in order.
    always @(posedge i_clk) begin
        logic took;
        logic next_push;
        logic next_we;
        if (!i_rst_n) begin
            i_push   <= 1'b0;
            i_cfg_we <= 1'b0;
        end else begin
            took      = i_push && !o_full;
            next_push = 1'b0;
            next_we   = 1'b0;
            if (took) begin
                expected_results.push_back(receive_word(i_rx_word));
                void'(pending_ops.pop_front());
                words_sent++;
                if ($urandom_range(0, 199) == 0) push_quiet = !push_quiet;
                push_gap = pick_gap(push_quiet);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NODE_ADDRESS: node_addr = i_cfg_data[4:0];
                    CFG_FRAME_LIMIT:  frame_lim = i_cfg_data[4:0];
                    CFG_ASK_CODE:     ask_code  = i_cfg_data;
                    default: ;
                endcase
                void'(pending_ops.pop_front());
                cfg_writes++;
            end
            // Register writes wait until every result is out and cfg_settle has counted down.
            if (expected_results.size() != 0) cfg_settle = CFG_SETTLE;
            if (i_push && !took) begin
                next_push = 1'b1;
            end else if (push_gap > 0) begin
                push_gap--;
            end else if (pending_ops.size() != 0) begin
                if (pending_ops[0].kind == OP_WORD) begin
                    next_push = 1'b1;
                    i_rx_word <= pending_ops[0].word;
                end else if (!i_cfg_we) begin
                    if (cfg_settle > 0) begin
                        cfg_settle--;
                    end else begin
                        next_we = 1'b1;
                        i_cfg_index <= pending_ops[0].cfg_index;
                        i_cfg_data  <= pending_ops[0].cfg_data;
                        cfg_settle = CFG_SETTLE;
                    end
                end
            end
            i_push   <= next_push;
            i_cfg_we <= next_we;
        end
    end

    // Monitor: checks each result transfer against the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (i_pop && !o_empty) begin
                if (expected_results.size() == 0) begin
                    $error("result with no word waiting for it: status %0d", o_status);
                    failures++;
                end else begin
                    want = expected_results.pop_front();
                    status_seen[want.status]++;
                    check_field("status", 16'(want.status), 16'(o_status));
                    check_field("data_byte", 16'(want.data_byte), 16'(o_data_byte));
                    check_field("byte_index", 16'(want.byte_index), 16'(o_byte_index));
                    check_field("command_byte", 16'(want.command_byte), 16'(o_command_byte));
                    check_field("ask_total", want.ask_total, o_ask_total);
                    check_field("receiving", 16'(want.receiving), 16'(o_receiving));
                end
                if ($urandom_range(0, 199) == 0) pop_quiet = !pop_quiet;
                pop_gap = pick_gap(pop_quiet);
            end
            if (pop_gap > 0) begin
                pop_gap--;
                i_pop <= 1'b0;
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $error("run did not finish within %0d cycles", CYCLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int         roll;
        int         lim;
        int         target;
        logic [4:0] node;
        logic [7:0] ask;
        logic [7:0] len;

        // Words while idle are ignored, as is a foreign address.
        queue_word(9'h000);
        queue_word(9'h1ff);
        // Good frame carrying the ask command; the address word has its high bits set.
        queue_word(9'h1e2);
        queue_word(9'h003);
        queue_word(9'h01d);
        queue_word(9'h0ff);
        queue_word({1'b0, 8'h03 ^ 8'h1d ^ 8'hff});
        // A foreign address inside a frame is skipped; the checksum here is wrong.
        queue_word(9'h102);
        queue_word(9'h002);
        queue_word(9'h103);
        queue_word(9'h012);
        queue_word(9'h011);
        // Zero length completes on the first byte.
        queue_word(9'h102);
        queue_word(9'h000);
        // Length above the limit aborts; the byte after it is ignored.
        queue_word(9'h102);
        queue_word(9'h01f);
        queue_word(9'h044);
        // A matching address restarts a frame that is still open.
        queue_word(9'h102);
        queue_word(9'h005);
        queue_word(9'h102);
        queue_word(9'h001);
        queue_word(9'h0ff);
        queue_word(9'h0fe);
        // With a limit of one the second byte hits the byte counter limit.
        queue_cfg(CFG_FRAME_LIMIT, 8'd1);
        queue_word(9'h102);
        queue_word(9'h001);
        queue_word(9'h080);
        queue_word(9'h100);

        // Random phases, each with its own register settings.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin node = 5'd0;  lim = 31; ask = 8'h00; end
                1: begin node = 5'd31; lim = 1;  ask = 8'hff; end
                default: begin
                    node = 5'($urandom);
                    lim  = (phase == 4) ? 31 : $urandom_range(2, 12);
                    ask  = 8'($urandom);
                end
            endcase
            queue_cfg(CFG_NODE_ADDRESS, {3'($urandom_range(0, 7)), node});
            queue_cfg(CFG_FRAME_LIMIT, {3'($urandom_range(0, 7)), 5'(lim)});
            queue_cfg(CFG_ASK_CODE, ask);
            target = frame_words + RANDOM_WORDS / PHASES;
            while (frame_words < target) begin
                roll = $urandom_range(0, 99);
                if (roll < 75) begin
                    len = (roll < 8) ? 8'(lim) : 8'($urandom_range(0, lim));
                    queue_frame(node, len, $urandom_range(0, 1) ? ask : 8'($urandom),
                                $urandom_range(0, 4) == 0, 300);
                end else if (roll < 83) begin
                    queue_frame(node, 8'($urandom_range(lim + 1, 255)), 8'($urandom), 1'b0,
                                $urandom_range(1, 3));
                end else if (roll < 90) begin
                    len = 8'($urandom_range(1, lim));
                    queue_frame(node, len, ask, 1'b0, $urandom_range(0, int'(len)));
                end else if (roll < 95) begin
                    queue_word({1'b1, 3'($urandom_range(0, 7)),
                                node ^ 5'($urandom_range(1, 31))});
                end else begin
                    queue_word(9'($urandom_range(0, 511)));
                end
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            failures++;
        end

        $display("Sent %0d words and %0d register writes over %0d register settings.",
                 words_sent, cfg_writes, PHASES + 2);
        $display("Saw %0d good frames, %0d checksum errors, %0d aborts, %0d mismatches.",
                 status_seen[ST_GOOD], status_seen[ST_XOR_ERR], status_seen[ST_ABORT],
                 failures);
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/mfr_pkg.sv
hw/rtl/mfr_front.sv
hw/rtl/mfr_back.sv
hw/rtl/multidrop_frame_receiver.sv
test/multidrop_frame_receiver_test.sv
